[hdl/pdtc_pkg.sv]
// Package for the PD position torque controller: register indexes, widths and config type.
`default_nettype none
package pdtc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_KP_GAIN        = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KD_RATE_GAIN   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TORQUE_LIMIT   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TARGET_INITIAL = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TARGET_STEP    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TARGET_MAX     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TARGET_MIN     = 3'd6;

  localparam logic [15:0] KP_RESET        = 16'd128;
  localparam logic [15:0] KD_RESET        = 16'd5120;
  localparam logic [14:0] LIMIT_RESET     = 15'd1280;
  localparam logic [14:0] INITIAL_RESET   = 15'd2560;
  localparam logic [14:0] STEP_RESET      = 15'd1280;
  localparam logic [14:0] MAX_RESET       = 15'd6400;
  localparam logic [14:0] MIN_RESET       = 15'd1280;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 56;

  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] kd_rate_gain;
    logic [14:0] torque_limit;
    logic [14:0] target_initial;
    logic [14:0] target_step;
    logic [14:0] target_max;
    logic [14:0] target_min;
  } cfg_t;

endpackage
`default_nettype wire

[hdl/pdtc_sat.sv]
// Torque sum, floor scaling by 1/256 and symmetric saturation.
`default_nettype none
module pdtc_sat (
  input  wire logic signed [33:0] p_kp,
  input  wire logic signed [34:0] p_kd,
  input  wire logic        [14:0] torque_limit,
  output logic signed      [15:0] torque_cmd,
  output logic                    torque_limited
);
  import pdtc_pkg::*;

  logic signed [35:0] sum;
  logic signed [27:0] raw;
  logic signed [27:0] lim_pos;
  logic signed [27:0] lim_neg;

  always_comb begin
    sum     = {{2{p_kp[33]}}, p_kp} + {p_kd[34], p_kd};
    raw     = sum[35:8];
    lim_pos = $signed({13'd0, torque_limit});
    lim_neg = -lim_pos;
    if (raw > lim_pos) begin
      torque_cmd     = lim_pos[15:0];
      torque_limited = 1'b1;
    end else if (raw < lim_neg) begin
      torque_cmd     = lim_neg[15:0];
      torque_limited = 1'b1;
    end else begin
      torque_cmd     = raw[15:0];
      torque_limited = 1'b0;
    end
  end

endmodule
`default_nettype wire

[hdl/pd_position_torque_controller.sv]
// Top level of the PD position torque controller: config registers, target state, pipeline.
`default_nettype none
// Each input transfer is one control tick: it updates the target from the clicks, forms the
// position error and a saturated PD torque, and yields exactly one result transfer. Ticks go
// through two register stages (input, result): one pass of logic between them forms the target,
// the error, both products, the sum and the clamp. A new tick can be taken every cycle unless
// the output stalls; each stage holds while the next one is full and stalled. Input and
// configuration are not ready during reset. Configuration writes are otherwise always ready and
// must be made while no tick is in flight; a new target_initial applies at the next inactive
// tick.
module pd_position_torque_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // motor_angle[15:0], assist_active[16], flip_click[17], step_click[18], zero [23:19]
  input  wire logic [pdtc_pkg::InDataW-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // torque_cmd[15:0], target_pos[31:16], position_error[48:32], torque_limited[49],
  // zero [55:50]
  output logic [pdtc_pkg::OutDataW-1:0]      out_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pdtc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [pdtc_pkg::CfgDataW-1:0] cfg_data
);
  import pdtc_pkg::*;

  cfg_t cfg_r;

  logic               s0_valid_r;
  logic signed [15:0] s0_angle_r;
  logic               s0_active_r;
  logic               s0_flip_r;
  logic               s0_step_r;

  logic               out_valid_r;
  logic [OutDataW-1:0] out_data_r;

  logic signed [16:0] last_error_r;
  logic               target_negative_r;
  logic [14:0]        target_magnitude_r;

  logic               s0_ready;
  logic               out_ready_int;
  logic               s0_move;

  logic               neg_nxt;
  logic [15:0]        step_sum;
  logic [14:0]        mag_nxt;
  logic signed [15:0] target_nxt;
  logic signed [16:0] error_nxt;
  logic signed [17:0] diff_nxt;
  logic signed [16:0] last_error_nxt;

  logic signed [33:0] p_kp;
  logic signed [34:0] p_kd;

  logic signed [15:0] torque;
  logic               limited;

  assign cfg_ready     = rst_n;
  assign out_ready_int = !out_valid_r || out_tready;
  assign s0_ready      = !s0_valid_r || out_ready_int;
  assign in_tready     = rst_n && s0_ready;
  assign s0_move       = s0_valid_r && out_ready_int;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain        <= KP_RESET;
      cfg_r.kd_rate_gain   <= KD_RESET;
      cfg_r.torque_limit   <= LIMIT_RESET;
      cfg_r.target_initial <= INITIAL_RESET;
      cfg_r.target_step    <= STEP_RESET;
      cfg_r.target_max     <= MAX_RESET;
      cfg_r.target_min     <= MIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KP_GAIN:        cfg_r.kp_gain        <= cfg_data;
        REG_KD_RATE_GAIN:   cfg_r.kd_rate_gain   <= cfg_data;
        REG_TORQUE_LIMIT:   cfg_r.torque_limit   <= cfg_data[14:0];
        REG_TARGET_INITIAL: cfg_r.target_initial <= cfg_data[14:0];
        REG_TARGET_STEP:    cfg_r.target_step    <= cfg_data[14:0];
        REG_TARGET_MAX:     cfg_r.target_max     <= cfg_data[14:0];
        REG_TARGET_MIN:     cfg_r.target_min     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    step_sum = {1'b0, target_magnitude_r} + {1'b0, cfg_r.target_step};
    if (!s0_active_r) begin
      neg_nxt        = 1'b0;
      mag_nxt        = cfg_r.target_initial;
      target_nxt     = $signed({1'b0, cfg_r.target_initial});
      error_nxt      = '0;
      diff_nxt       = '0;
      last_error_nxt = '0;
    end else begin
      neg_nxt = target_negative_r ^ s0_flip_r;
      if (!s0_step_r) begin
        mag_nxt = target_magnitude_r;
      end else if (step_sum > {1'b0, cfg_r.target_max}) begin
        mag_nxt = cfg_r.target_min;
      end else begin
        mag_nxt = step_sum[14:0];
      end
      target_nxt     = neg_nxt ? -$signed({1'b0, mag_nxt}) : $signed({1'b0, mag_nxt});
      error_nxt      = {target_nxt[15], target_nxt} - {s0_angle_r[15], s0_angle_r};
      diff_nxt       = {error_nxt[16], error_nxt} - {last_error_r[16], last_error_r};
      last_error_nxt = error_nxt;
    end
    p_kp = $signed({18'd0, cfg_r.kp_gain}) * $signed({{17{error_nxt[16]}}, error_nxt});
    p_kd = $signed({19'd0, cfg_r.kd_rate_gain}) * $signed({{17{diff_nxt[17]}}, diff_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      last_error_r       <= '0;
      target_negative_r  <= 1'b0;
      target_magnitude_r <= INITIAL_RESET;
    end else begin
      if (s0_ready) begin
        s0_valid_r <= in_tvalid;
      end
      if (out_ready_int) begin
        out_valid_r <= s0_valid_r;
      end
      if (s0_move) begin
        last_error_r       <= last_error_nxt;
        target_negative_r  <= neg_nxt;
        target_magnitude_r <= mag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_angle_r  <= $signed(in_tdata[15:0]);
      s0_active_r <= in_tdata[16];
      s0_flip_r   <= in_tdata[17];
      s0_step_r   <= in_tdata[18];
    end
    if (s0_move) begin
      out_data_r <= {6'd0, limited, error_nxt, target_nxt, torque};
    end
  end

  pdtc_sat u_sat (
    .p_kp           (p_kp),
    .p_kd           (p_kd),
    .torque_limit   (cfg_r.torque_limit),
    .torque_cmd     (torque),
    .torque_limited (limited)
  );

endmodule
`default_nettype wire

[tb/pd_position_torque_controller_tb.sv]
// Self-checking testbench for the PD position torque controller with its own tick predictor.
`timescale 1ns / 1ps
module pd_position_torque_controller_tb;
  import pdtc_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
  localparam int SEG_ITEMS = 150;
  localparam int SEG_COUNT = 9;
  localparam int HOLD_CYCLES = 64;

  typedef struct packed {
    logic signed [15:0] angle;
    logic               active;
    logic               flip;
    logic               step;
  } tick_in_t;

  typedef struct packed {
    logic [15:0] torque;
    logic [15:0] target;
    logic [16:0] pos_err;
    logic        limited;
  } tick_result_t;

  typedef struct packed {
    tick_in_t     stim;
    logic         typed;
    tick_result_t want;
  } drill_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  cfg_t               gains;
  logic signed [16:0] prev_err;
  logic               tgt_negative;
  logic [14:0]        tgt_mag;

  tick_result_t torque_expected[$];
  drill_row_t   drill_rows[$];
  int           mismatch_count = 0;
  int           tx_idle_pct = 14;
  int           rx_idle_pct = 81;
  logic         rx_hold = 1'b0;
  bit           hold_go = 1'b0;

  pd_position_torque_controller dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic log_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic tick_result_t pd_tick_predict(input tick_in_t t);
    tick_result_t r;
    int           sum;
    int           tgt;
    int           err;
    longint       raw;
    longint       lim;
    r = '0;
    if (!t.active) begin
      prev_err = '0;
      tgt_negative = 1'b0;
      tgt_mag = gains.target_initial;
      r.target = {1'b0, tgt_mag};
      return r;
    end
    if (t.flip) tgt_negative = !tgt_negative;
    if (t.step) begin
      sum = int'(tgt_mag) + int'(gains.target_step);
      tgt_mag = (sum > int'(gains.target_max)) ? gains.target_min : sum[14:0];
    end
    tgt = tgt_negative ? -int'(tgt_mag) : int'(tgt_mag);
    err = tgt - int'(t.angle);
    raw = (longint'(gains.kp_gain) * err
           + longint'(gains.kd_rate_gain) * (err - int'(prev_err))) >>> 8;
    lim = longint'(gains.torque_limit);
    if (raw > lim) begin
      raw = lim;
      r.limited = 1'b1;
    end else if (raw < -lim) begin
      raw = -lim;
      r.limited = 1'b1;
    end
    prev_err = err[16:0];
    r.torque = raw[15:0];
    r.target = tgt[15:0];
    r.pos_err = err[16:0];
    return r;
  endfunction

  always @(posedge clk) begin : rx_side
    tick_result_t got;
    tick_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got.torque = out_tdata[15:0];
      got.target = out_tdata[31:16];
      got.pos_err = out_tdata[48:32];
      got.limited = out_tdata[49];
      if (torque_expected.size() == 0) begin
        log_mismatch("result with no tick pending, torque_cmd", $signed(got.torque), 0);
      end else begin
        want = torque_expected.pop_front();
        if (got.torque !== want.torque)
          log_mismatch("torque_cmd", $signed(got.torque), $signed(want.torque));
        if (got.target !== want.target)
          log_mismatch("target_pos", $signed(got.target), $signed(want.target));
        if (got.pos_err !== want.pos_err)
          log_mismatch("position_error", $signed(got.pos_err), $signed(want.pos_err));
        if (got.limited !== want.limited)
          log_mismatch("torque_limited", got.limited, want.limited);
      end
    end
    out_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_tick(input tick_in_t t, input logic typed, input tick_result_t want);
    tick_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, t.step, t.flip, t.active, t.angle};
    do @(posedge clk); while (!in_tready);
    predicted = pd_tick_predict(t);
    torque_expected.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    while (torque_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KP_GAIN:        gains.kp_gain = data;
      REG_KD_RATE_GAIN:   gains.kd_rate_gain = data;
      REG_TORQUE_LIMIT:   gains.torque_limit = data[14:0];
      REG_TARGET_INITIAL: gains.target_initial = data[14:0];
      REG_TARGET_STEP:    gains.target_step = data[14:0];
      REG_TARGET_MAX:     gains.target_max = data[14:0];
      REG_TARGET_MIN:     gains.target_min = data[14:0];
      default: ;
    endcase
  endtask

  task automatic program_gains(input logic [15:0] kp, input logic [15:0] kd,
                               input logic [14:0] lim, input logic [14:0] init,
                               input logic [14:0] stp, input logic [14:0] mx,
                               input logic [14:0] mn);
    logic [5:0]  junk;
    logic [15:0] noise;
    junk = 6'($urandom);
    noise = 16'($urandom);
    set_reg(REG_KP_GAIN, kp);
    set_reg(REG_KD_RATE_GAIN, kd);
    set_reg(REG_TORQUE_LIMIT, {junk[0], lim});
    set_reg(REG_TARGET_INITIAL, {junk[1], init});
    set_reg(REG_TARGET_STEP, {junk[2], stp});
    set_reg(REG_TARGET_MAX, {junk[3], mx});
    set_reg(REG_TARGET_MIN, {junk[4], mn});
    set_reg(REG_UNUSED, noise);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_random();
    int kp;
    int kd;
    int lim;
    int mx;
    kp = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1023);
    kd = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(8191);
    lim = ($urandom_range(1) == 0) ? $urandom_range(32767) : $urandom_range(4000);
    mx = $urandom_range(20000, 200);
    program_gains(16'(kp), 16'(kd), 15'(lim), 15'($urandom_range(mx + 2000)),
                  15'($urandom_range(mx / 3 + 1)), 15'(mx), 15'($urandom_range(mx + 500)));
  endtask

  task automatic add_row(input int angle, input logic act, input logic flp, input logic stp,
                         input logic typed, input int w_torque, input int w_target,
                         input int w_err, input logic w_lim);
    drill_row_t row;
    row.stim.angle = 16'(angle);
    row.stim.active = act;
    row.stim.flip = flp;
    row.stim.step = stp;
    row.typed = typed;
    row.want.torque = 16'(w_torque);
    row.want.target = 16'(w_target);
    row.want.pos_err = 17'(w_err);
    row.want.limited = w_lim;
    drill_rows.push_back(row);
  endtask

  task automatic walk_rows();
    foreach (drill_rows[i]) send_tick(drill_rows[i].stim, drill_rows[i].typed,
                                      drill_rows[i].want);
    in_tvalid <= 1'b0;
    drill_rows.delete();
    drain_results();
  endtask

  task automatic run_random(input int count);
    tick_in_t t;
    int       aim;
    repeat (count) begin
      t.active = ($urandom_range(99) < 92);
      t.flip = ($urandom_range(99) < 12);
      t.step = ($urandom_range(99) < 20);
      if ($urandom_range(3) == 0) begin
        t.angle = 16'($urandom);
      end else begin
        aim = (tgt_negative ? -int'(tgt_mag) : int'(tgt_mag))
              + int'($urandom_range(600)) - 300;
        if (aim > 32767) aim = 32767;
        if (aim < -32768) aim = -32768;
        t.angle = 16'(aim);
      end
      send_tick(t, 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    drain_results();
  endtask

  initial begin
    gains.kp_gain = KP_RESET;
    gains.kd_rate_gain = KD_RESET;
    gains.torque_limit = LIMIT_RESET;
    gains.target_initial = INITIAL_RESET;
    gains.target_step = STEP_RESET;
    gains.target_max = MAX_RESET;
    gains.target_min = MIN_RESET;
    prev_err = '0;
    tgt_negative = 1'b0;
    tgt_mag = INITIAL_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: idle ticks, angle extremes, clicks and wrap
    add_row(0, 0, 0, 0, 1, 0, 2560, 0, 0);
    add_row(-32768, 0, 1, 1, 1, 0, 2560, 0, 0);
    add_row(-32768, 1, 0, 0, 1, 1280, 2560, 35328, 1);
    add_row(32767, 1, 0, 0, 1, -1280, 2560, -30207, 1);
    add_row(2560, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(2560, 1, 0, 0, 1, 0, 2560, 0, 0);
    add_row(0, 1, 1, 0, 0, 0, 0, 0, 0);
    add_row(0, 1, 0, 1, 0, 0, 0, 0, 0);
    add_row(-100, 1, 1, 1, 0, 0, 0, 0, 0);
    add_row(5000, 1, 0, 1, 0, 0, 0, 0, 0);
    add_row(6400, 1, 0, 1, 0, 0, 0, 0, 0);
    add_row(1200, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(1300, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(123, 0, 1, 0, 1, 0, 2560, 0, 0);
    walk_rows();

    // zero limit, initial above max, min above max, step sum past 15 bits
    program_gains(16'hFFFF, 16'hFFFF, 15'd0, 15'h7FFF, 15'h7FFF, 15'd100, 15'd30000);
    add_row(32767, 0, 0, 0, 1, 0, 32767, 0, 0);
    add_row(-32768, 1, 0, 0, 1, 0, 32767, 65535, 1);
    add_row(32767, 1, 1, 0, 1, 0, -32767, -65534, 1);
    add_row(0, 1, 0, 1, 0, 0, 0, 0, 0);
    add_row(-30000, 1, 0, 1, 0, 0, 0, 0, 0);
    add_row(-30000, 1, 0, 0, 1, 0, -30000, 0, 0);
    add_row(0, 0, 0, 0, 1, 0, 32767, 0, 0);
    walk_rows();

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg / 3)
        0: begin
          tx_idle_pct = 14;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 14;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (seg)
        0: program_gains(KP_RESET, KD_RESET, LIMIT_RESET, INITIAL_RESET, STEP_RESET,
                         MAX_RESET, MIN_RESET);
        2: program_gains(16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
                         15'h7FFF);
        4: program_gains(16'h0000, 16'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000,
                         15'h0000);
        default: program_random();
      endcase
      // hold the result side while the input keeps streaming
      if (seg == 6) hold_go = 1'b1;
      run_random(SEG_ITEMS);
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
